[hw/rtl/u8v_pkg.sv]
// Shared types and constants for the UTF-8 string validator.
`default_nettype none
package u8v_pkg;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
	localparam logic [1:0] STATUS_INVALID  = 2'd2;

	// Allowed range of the next continuation byte
	localparam logic [2:0] RANGE_80_BF = 3'd0;
	localparam logic [2:0] RANGE_A0_BF = 3'd1;
	localparam logic [2:0] RANGE_80_9F = 3'd2;
	localparam logic [2:0] RANGE_90_BF = 3'd3;
	localparam logic [2:0] RANGE_80_8F = 3'd4;

	localparam int          LEN_W       = 17;
	localparam logic [16:0] LEN_SAT     = 17'h1FFFF;
	localparam logic [15:0] MAX_LEN_RST = 16'd8192;

	// Per-string decoder state
	typedef struct packed {
		logic [1:0]       pending_count;
		logic [2:0]       next_range_class;
		logic             error_seen;
		logic [LEN_W-1:0] length_count;
	} u8v_state_t;

	// Outcome of one request
	typedef struct packed {
		logic       has_result;
		logic [1:0] status;
	} u8v_result_t;

endpackage
`default_nettype wire

[hw/rtl/u8v_if.sv]
// Request and response stream interfaces of the UTF-8 string validator.
`default_nettype none
interface u8v_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_string;

	modport source (output valid, data_byte, last_byte, empty_string, input ready);
	modport sink   (input valid, data_byte, last_byte, empty_string, output ready);
endinterface

interface u8v_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;

	modport source (output valid, status, input ready);
	modport sink   (input valid, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/u8v_step.sv]
// Per-byte UTF-8 check: next decoder state and end-of-string status.
`default_nettype none
module u8v_step
	import u8v_pkg::*;
(
	input  wire u8v_state_t  cur,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        empty_string,
	input  wire logic [15:0] max_length,
	output u8v_state_t       nxt,
	output u8v_result_t      res
);

	logic       cont_ok;
	logic [1:0] dec_pending;
	logic [2:0] dec_class;
	logic       dec_error;
	logic [LEN_W-1:0] len_inc;

	// Continuation byte against the expected range; unused classes act as plain
	always_comb begin
		unique case (cur.next_range_class)
			RANGE_A0_BF: cont_ok = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
			RANGE_80_9F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
			RANGE_90_BF: cont_ok = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
			RANGE_80_8F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
			default:     cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
		endcase
	end

	// Byte decode; once an error is seen the string is no longer decoded
	always_comb begin
		dec_pending = cur.pending_count;
		dec_class   = cur.next_range_class;
		dec_error   = cur.error_seen;
		if (!cur.error_seen) begin
			if (cur.pending_count != 2'd0) begin
				dec_class = RANGE_80_BF;
				if (cont_ok) begin
					dec_pending = cur.pending_count - 2'd1;
				end else begin
					dec_pending = 2'd0;
					dec_error   = 1'b1;
				end
			end else begin
				case (data_byte) inside
					8'h09, 8'h0A, 8'h0D, [8'h20:8'h7E]: begin
					end
					[8'hC2:8'hDF]: begin
						dec_pending = 2'd1;
						dec_class   = RANGE_80_BF;
					end
					8'hE0: begin
						dec_pending = 2'd2;
						dec_class   = RANGE_A0_BF;
					end
					8'hED: begin
						dec_pending = 2'd2;
						dec_class   = RANGE_80_9F;
					end
					[8'hE1:8'hEF]: begin
						dec_pending = 2'd2;
						dec_class   = RANGE_80_BF;
					end
					8'hF0: begin
						dec_pending = 2'd3;
						dec_class   = RANGE_90_BF;
					end
					8'hF4: begin
						dec_pending = 2'd3;
						dec_class   = RANGE_80_8F;
					end
					[8'hF1:8'hF3]: begin
						dec_pending = 2'd3;
						dec_class   = RANGE_80_BF;
					end
					default: dec_error = 1'b1;
				endcase
			end
		end
	end

	// Saturating length count including this byte
	assign len_inc = (cur.length_count == LEN_SAT) ? cur.length_count
	                                               : cur.length_count + 17'd1;

	// Next state and result
	always_comb begin
		nxt            = '0;
		res.has_result = 1'b0;
		res.status     = STATUS_OK;
		if (empty_string) begin
			res.has_result = 1'b1;
		end else if (last_byte) begin
			res.has_result = 1'b1;
			if (len_inc > {1'b0, max_length}) begin
				res.status = STATUS_TOO_LONG;
			end else if (dec_error || (dec_pending != 2'd0)) begin
				res.status = STATUS_INVALID;
			end
		end else begin
			nxt.pending_count    = dec_pending;
			nxt.next_range_class = dec_class;
			nxt.error_seen       = dec_error;
			nxt.length_count     = len_inc;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/utf8_string_validator_top.sv]
// Top level of the UTF-8 string validator: input stage, decoder state, result register.
//
// Usage:
//   req carries one string byte per request (data_byte, last_byte, empty_string).
//   rsp carries one status per string: 0 valid, 1 too long, 2 invalid UTF-8.
//   A result appears for the request that has last_byte set, or empty_string set;
//   other bytes produce no result. cfg_wr_en/cfg_wr_data load max_length
//   (reset 8192); write it only while the block is idle.
// Timing:
//   One request per clock is accepted unless req.ready drops (see Backpressure).
//   A request is registered in the input stage, checked there by the single-pass
//   decoder, and its status is then registered in the result register.
//   The decoder state is a single register updated once per byte, so a byte
//   may follow in the very next cycle.
// Reset:
//   arst_n clears the decoder state, both valid flags and sets max_length to 8192.
// Backpressure:
//   While rsp is stalled, the input stage still moves bytes that give no
//   result; a final byte waits in the input stage and req.ready drops only
//   when the input stage holds a waiting result.
`default_nettype none
module utf8_string_validator_top
	import u8v_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	u8v_req_if.sink          req,
	u8v_rsp_if.source        rsp,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        last_byte_s1;
	logic        empty_string_s1;
	logic [15:0] max_length_q;
	u8v_state_t  state_q;
	u8v_state_t  state_nxt;
	u8v_result_t res;
	logic        rsp_valid_q;
	logic [1:0]  status_q;
	logic        out_free;
	logic        s1_go;
	logic        req_take;

	// Handshake: stage 1 moves unless it holds a result and the output is full
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign s1_go     = valid_s1 && (!res.has_result || out_free);
	assign req.ready = !valid_s1 || s1_go;
	assign req_take  = req.valid && req.ready;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			data_byte_s1    <= req.data_byte;
			last_byte_s1    <= req.last_byte;
			empty_string_s1 <= req.empty_string;
		end
	end

	// Decoder
	u8v_step u_step (
		.cur          (state_q),
		.data_byte    (data_byte_s1),
		.last_byte    (last_byte_s1),
		.empty_string (empty_string_s1),
		.max_length   (max_length_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go && res.has_result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res.has_result) begin
			status_q <= res.status;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the UTF-8 string validator top level.
`timescale 1ns / 1ps

module tb;
	import u8v_pkg::*;

	// One row of the directed table; status is used only where typed is set
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       typed;
		logic [1:0] status;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	u8v_req_if req_ch ();
	u8v_rsp_if rsp_ch ();

	utf8_string_validator_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Predictor state and the statuses still owed by the block
	u8v_state_t  utf8_st;
	logic [15:0] max_len_cfg;
	logic [1:0]  status_q[$];
	int          fails;
	int          items_sent;

	// Typed expectation that travels with a directed request
	logic        req_typed;
	logic [1:0]  req_typed_st;

	// 0: sender 36%, receiver 50% idle; 1: the reverse; 2: no idling
	int          idle_mode;
	int          hold_req;
	int          hold_ack;
	int          stall_left;

	logic [7:0]  str_bytes[$];

	dir_row_t dir_tbl [25] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, STATUS_OK},       // empty, last clear
		'{8'hFF, 1'b1, 1'b1, 1'b1, STATUS_OK},       // empty, byte ignored
		'{8'h09, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h0A, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h0D, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h20, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h7E, 1'b1, 1'b0, 1'b1, STATUS_OK},
		'{8'h7F, 1'b1, 1'b0, 1'b1, STATUS_INVALID},  // DEL not allowed
		'{8'hC2, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h80, 1'b1, 1'b0, 1'b1, STATUS_OK},
		'{8'hE0, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h9F, 1'b0, 1'b0, 1'b0, STATUS_OK},       // overlong after E0
		'{8'h80, 1'b1, 1'b0, 1'b1, STATUS_INVALID},
		'{8'hED, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'hA0, 1'b1, 1'b0, 1'b1, STATUS_INVALID},  // surrogate
		'{8'hF4, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h8F, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'hBF, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'hBF, 1'b1, 1'b0, 1'b0, STATUS_OK},
		'{8'hF0, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h90, 1'b1, 1'b0, 1'b1, STATUS_INVALID},  // cut short at the end
		'{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h41, 1'b1, 1'b0, 1'b1, STATUS_INVALID},  // sticky after a bad byte
		'{8'hC2, 1'b0, 1'b0, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, 1'b1, 1'b1, STATUS_OK}        // empty drops open string
	};

	// Clock and reset
	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Random byte in an inclusive range
	function automatic logic [7:0] rnd_byte(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	// Random single bit
	function automatic logic rnd_bit();
		return 1'($urandom_range(1, 0));
	endfunction

	// Allowed range of a continuation byte for a given range class
	function automatic logic cont_fits(input logic [7:0] b, input logic [2:0] cls);
		case (cls)
			RANGE_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
			RANGE_80_9F: return b >= 8'h80 && b <= 8'h9F;
			RANGE_90_BF: return b >= 8'h90 && b <= 8'hBF;
			RANGE_80_8F: return b >= 8'h80 && b <= 8'h8F;
			default:     return b >= 8'h80 && b <= 8'hBF;
		endcase
	endfunction

	// Advance the predicted decoder by one request
	task automatic utf8_advance(input logic [7:0] b, input logic l, input logic e,
			output logic has, output logic [1:0] st);
		has = 1'b0;
		st  = STATUS_OK;
		if (e) begin
			utf8_st = '0;
			has     = 1'b1;
			return;
		end
		if (utf8_st.length_count != LEN_SAT)
			utf8_st.length_count = utf8_st.length_count + 17'd1;
		if (!utf8_st.error_seen) begin
			if (utf8_st.pending_count != 2'd0) begin
				if (cont_fits(b, utf8_st.next_range_class)) begin
					utf8_st.pending_count = utf8_st.pending_count - 2'd1;
				end else begin
					utf8_st.error_seen    = 1'b1;
					utf8_st.pending_count = 2'd0;
				end
				utf8_st.next_range_class = RANGE_80_BF;
			end else if (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E)) begin
				// plain single-byte character
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				utf8_st.pending_count    = 2'd1;
				utf8_st.next_range_class = RANGE_80_BF;
			end else if (b == 8'hE0) begin
				utf8_st.pending_count    = 2'd2;
				utf8_st.next_range_class = RANGE_A0_BF;
			end else if (b == 8'hED) begin
				utf8_st.pending_count    = 2'd2;
				utf8_st.next_range_class = RANGE_80_9F;
			end else if (b >= 8'hE1 && b <= 8'hEF) begin
				utf8_st.pending_count    = 2'd2;
				utf8_st.next_range_class = RANGE_80_BF;
			end else if (b == 8'hF0) begin
				utf8_st.pending_count    = 2'd3;
				utf8_st.next_range_class = RANGE_90_BF;
			end else if (b == 8'hF4) begin
				utf8_st.pending_count    = 2'd3;
				utf8_st.next_range_class = RANGE_80_8F;
			end else if (b >= 8'hF1 && b <= 8'hF3) begin
				utf8_st.pending_count    = 2'd3;
				utf8_st.next_range_class = RANGE_80_BF;
			end else begin
				utf8_st.error_seen = 1'b1;
			end
		end
		if (l) begin
			has = 1'b1;
			// length is checked before validity
			if (utf8_st.length_count > {1'b0, max_len_cfg})
				st = STATUS_TOO_LONG;
			else if (utf8_st.error_seen || utf8_st.pending_count != 2'd0)
				st = STATUS_INVALID;
			utf8_st = '0;
		end
	endtask

	// Check responses, then predict accepted requests
	always @(posedge clk) begin
		logic       has;
		logic [1:0] st;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (status_q.size() == 0) begin
					$display("%0t unexpected status: expected none, actual %0d",
						$time, rsp_ch.status);
					fails++;
				end else begin
					st = status_q.pop_front();
					if (rsp_ch.status !== st) begin
						$display("%0t status mismatch: expected %0d, actual %0d",
							$time, st, rsp_ch.status);
						fails++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				utf8_advance(req_ch.data_byte, req_ch.last_byte, req_ch.empty_string, has, st);
				if (has)
					status_q.push_back(req_typed ? req_typed_st : st);
			end
		end
	end

	// Response side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack     <= hold_req;
			stall_left   <= 300;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (idle_mode)
				0:       rsp_ch.ready <= $urandom_range(0, 99) >= 50;
				1:       rsp_ch.ready <= $urandom_range(0, 99) >= 36;
				default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	// Offer one request and wait until it is taken
	task automatic send_req(input logic [7:0] b, input logic l, input logic e,
			input logic typed, input logic [1:0] st);
		int pct;
		pct = (idle_mode == 0) ? 36 : (idle_mode == 1) ? 50 : 0;
		while ($urandom_range(0, 99) < pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.data_byte    <= b;
		req_ch.last_byte    <= l;
		req_ch.empty_string <= e;
		req_typed           <= typed;
		req_typed_st        <= st;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Stop sending and wait for every owed status, then for the pipeline
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [15:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		max_len_cfg = v;
	endtask

	// Append one well-formed character with random content
	task automatic push_char();
		int         kind;
		logic [7:0] lead;
		kind = $urandom_range(0, 9);
		case (kind)
			0: str_bytes.push_back(8'h09);
			1: str_bytes.push_back(8'h0A);
			2: str_bytes.push_back(8'h0D);
			3: str_bytes.push_back(rnd_byte(8'h20, 8'h7E));
			4: begin
				str_bytes.push_back(rnd_byte(8'hC2, 8'hDF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
			5: begin
				str_bytes.push_back(8'hE0);
				str_bytes.push_back(rnd_byte(8'hA0, 8'hBF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
			6: begin
				lead = rnd_byte(8'hE1, 8'hEF);
				if (lead == 8'hED)
					lead = 8'hEE;
				str_bytes.push_back(lead);
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
			7: begin
				str_bytes.push_back(8'hED);
				str_bytes.push_back(rnd_byte(8'h80, 8'h9F));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
			8: begin
				lead = rnd_byte(8'hF0, 8'hF3);
				str_bytes.push_back(lead);
				if (lead == 8'hF0)
					str_bytes.push_back(rnd_byte(8'h90, 8'hBF));
				else
					str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
			default: begin
				str_bytes.push_back(8'hF4);
				str_bytes.push_back(rnd_byte(8'h80, 8'h8F));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
				str_bytes.push_back(rnd_byte(8'h80, 8'hBF));
			end
		endcase
	endtask

	// One random string: mostly well-formed, some noise, damage, cuts and aborts
	task automatic send_string(input int maxc);
		int kind;
		int nchars;
		int cut;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			send_req(rnd_byte(0, 255), rnd_bit(), 1'b1, 1'b0, STATUS_OK);
			return;
		end
		str_bytes.delete();
		nchars = $urandom_range(1, maxc);
		if (kind < 12)
			repeat (nchars) str_bytes.push_back(rnd_byte(0, 255));
		else
			repeat (nchars) push_char();
		if (kind >= 12 && kind < 24)
			str_bytes[$urandom_range(0, str_bytes.size() - 1)] = rnd_byte(0, 255);
		else if (kind >= 24 && kind < 30 && str_bytes.size() > 1)
			void'(str_bytes.pop_back());
		cut = (kind >= 30 && kind < 34) ? int'($urandom_range(0, str_bytes.size() - 1)) : -1;
		foreach (str_bytes[i]) begin
			// empty request in the middle drops the open string
			if (i == cut) begin
				send_req(rnd_byte(0, 255), rnd_bit(), 1'b1, 1'b0, STATUS_OK);
				return;
			end
			send_req(str_bytes[i], i == str_bytes.size() - 1, 1'b0, 1'b0, STATUS_OK);
		end
	endtask

	task automatic run_strings(input int n_items, input int maxc);
		int start;
		start = items_sent;
		while (items_sent - start < n_items)
			send_string(maxc);
	endtask

	// Printable string of n bytes, used for the length boundaries
	task automatic send_long(input int n);
		for (int i = 0; i < n; i++)
			send_req(rnd_byte(8'h20, 8'h7E), i == n - 1, 1'b0, 1'b0, STATUS_OK);
	endtask

	// Main sequence
	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		req_ch.valid        = 1'b0;
		req_ch.data_byte    = '0;
		req_ch.last_byte    = 1'b0;
		req_ch.empty_string = 1'b0;
		rsp_ch.ready        = 1'b0;
		req_typed           = 1'b0;
		req_typed_st        = STATUS_OK;
		idle_mode           = 0;
		hold_req            = 0;
		hold_ack            = 0;
		stall_left          = 0;
		fails               = 0;
		items_sent          = 0;
		utf8_st             = '0;
		max_len_cfg         = MAX_LEN_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset length limit
		foreach (dir_tbl[i])
			send_req(dir_tbl[i].data, dir_tbl[i].last, dir_tbl[i].empty,
				dir_tbl[i].typed, dir_tbl[i].status);
		run_strings(300, 6);

		// small limit, then a long response stall with short strings
		write_max_length(16'd3);
		run_strings(300, 4);
		hold_req <= hold_req + 1;
		run_strings(60, 1);
		drain();

		idle_mode <= 1;
		write_max_length(16'hFFFF);
		run_strings(500, 8);
		write_max_length(16'd0);
		run_strings(100, 3);

		idle_mode <= 2;
		write_max_length(16'd12);
		run_strings(400, 5);

		// length boundaries around the limit
		write_max_length(16'd16);
		send_long(16);
		send_long(17);
		drain();

		if (fails == 0 && status_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/u8v_pkg.sv
hw/rtl/u8v_if.sv
hw/rtl/u8v_step.sv
hw/rtl/utf8_string_validator_top.sv
sim/tb.sv
